@@ rtl/bpa_pkg.sv @@
// Shared types and codes of the buddy page allocator.
package bpa_pkg;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OOM = 2'd1;
    localparam logic [1:0] ST_BIG = 2'd2;
    localparam logic [1:0] ST_DUP = 2'd3;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_A_SCAN,
        S_A_POP,
        S_A_SPLIT,
        S_F_RD,
        S_F_CHK,
        S_M_CHK,
        S_M_TEST,
        S_U_RD,
        S_U_CHK,
        S_U_FIX2,
        S_U_NEXT,
        S_EMIT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_J_INC,
        OP_A_TAKE,
        OP_A_POP,
        OP_A_SPLIT,
        OP_A_FINAL,
        OP_F_RD,
        OP_F_PUSH,
        OP_M_RD,
        OP_U_START_P,
        OP_U_START_B,
        OP_U_RD,
        OP_U_ADV,
        OP_U_FIX1,
        OP_U_FIX2,
        OP_M_PUSH,
        OP_RES_OOM,
        OP_RES_BIG,
        OP_RES_DUP,
        OP_RES_OKF,
        OP_EMIT
    } t_dp_op;

    typedef struct packed {
        logic clear_last;
        logic is_free_cmd;
        logic k_bad;
        logic p_bad;
        logic head_ok;
        logic j_last;
        logic j_gt_k;
        logic rd_bad;
        logic merge_stop;
        logic no_merge;
        logic walk_end;
        logic cur_hit;
        logic prev_nil;
        logic phase;
        logic out_busy;
    } t_dp_flags;

endpackage

@@ rtl/bpa_if.sv @@
// Request and response channel interfaces of the buddy page allocator.
interface bpa_req_if #(
    parameter int OW = 4,
    parameter int PW = 9
);
    logic          valid;
    logic          ready;
    logic          command;
    logic [OW-1:0] size_order;
    logic [PW-1:0] page_index;

    modport source (output valid, output command, output size_order, output page_index,
                    input ready);
    modport sink   (input valid, input command, input size_order, input page_index,
                    output ready);
endinterface

interface bpa_rsp_if #(
    parameter int PW = 9
);
    logic          valid;
    logic          ready;
    logic [1:0]    status;
    logic [PW-1:0] block_page;

    modport source (output valid, output status, output block_page, input ready);
    modport sink   (input valid, input status, input block_page, output ready);
endinterface

@@ rtl/bpa_ctrl.sv @@
// Sequencer of the buddy page allocator: picks one datapath operation per cycle.
module bpa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  bpa_pkg::t_dp_flags i_flags,
    output logic               o_in_ready,
    output bpa_pkg::t_dp_op    o_op
);
    import bpa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_flags.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (i_flags.is_free_cmd) begin
                    n_state = i_flags.p_bad ? S_EMIT : S_F_RD;
                end else begin
                    n_state = i_flags.k_bad ? S_EMIT : S_A_SCAN;
                end
            end
            S_A_SCAN: begin
                if (i_flags.head_ok) n_state = S_A_POP;
                else if (i_flags.j_last) n_state = S_EMIT;
            end
            S_A_POP:   n_state = S_A_SPLIT;
            S_A_SPLIT: begin
                if (!i_flags.j_gt_k) n_state = S_EMIT;
            end
            S_F_RD:    n_state = S_F_CHK;
            S_F_CHK:   n_state = i_flags.rd_bad ? S_EMIT : S_M_CHK;
            S_M_CHK:   n_state = i_flags.merge_stop ? S_EMIT : S_M_TEST;
            S_M_TEST:  n_state = i_flags.no_merge ? S_EMIT : S_U_RD;
            S_U_RD:    n_state = i_flags.walk_end ? S_U_NEXT : S_U_CHK;
            S_U_CHK: begin
                if (!i_flags.cur_hit) n_state = S_U_RD;
                else if (i_flags.prev_nil) n_state = S_U_NEXT;
                else n_state = S_U_FIX2;
            end
            S_U_FIX2:  n_state = S_U_NEXT;
            S_U_NEXT:  n_state = i_flags.phase ? S_M_CHK : S_U_RD;
            S_EMIT: begin
                if (!i_flags.out_busy) n_state = S_IDLE;
            end
            default:   n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_op       = OP_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR:  o_op = OP_CLEAR;
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_op = OP_LOAD;
            end
            S_DECODE: begin
                if (i_flags.is_free_cmd) begin
                    if (i_flags.p_bad) o_op = OP_RES_DUP;
                end else if (i_flags.k_bad) begin
                    o_op = OP_RES_BIG;
                end
            end
            S_A_SCAN: begin
                if (i_flags.head_ok) o_op = OP_A_TAKE;
                else if (i_flags.j_last) o_op = OP_RES_OOM;
                else o_op = OP_J_INC;
            end
            S_A_POP:   o_op = OP_A_POP;
            S_A_SPLIT: o_op = i_flags.j_gt_k ? OP_A_SPLIT : OP_A_FINAL;
            S_F_RD:    o_op = OP_F_RD;
            S_F_CHK:   o_op = i_flags.rd_bad ? OP_RES_DUP : OP_F_PUSH;
            S_M_CHK:   o_op = i_flags.merge_stop ? OP_RES_OKF : OP_M_RD;
            S_M_TEST:  o_op = i_flags.no_merge ? OP_RES_OKF : OP_U_START_P;
            S_U_RD:    o_op = i_flags.walk_end ? OP_NONE : OP_U_RD;
            S_U_CHK:   o_op = i_flags.cur_hit ? OP_U_FIX1 : OP_U_ADV;
            S_U_FIX2:  o_op = OP_U_FIX2;
            S_U_NEXT:  o_op = i_flags.phase ? OP_M_PUSH : OP_U_START_B;
            S_EMIT: begin
                if (!i_flags.out_busy) o_op = OP_EMIT;
            end
            default:   o_op = OP_NONE;
        endcase
    end

endmodule

@@ rtl/bpa_datapath.sv @@
// Page table memory, free list heads, walk registers and result register.
module bpa_datapath #(
    parameter int PAGE_COUNT   = 512,
    parameter int ORDER_LEVELS = 10,
    parameter int PW = $clog2(PAGE_COUNT),
    parameter int OW = $clog2(ORDER_LEVELS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bpa_pkg::t_dp_op    i_op,
    input  logic               i_command,
    input  logic [OW-1:0]      i_size_order,
    input  logic [PW-1:0]      i_page_index,
    input  logic               i_out_ready,
    output bpa_pkg::t_dp_flags o_flags,
    output logic               o_out_valid,
    output logic [1:0]         o_status,
    output logic [PW-1:0]      o_block_page
);
    import bpa_pkg::*;

    localparam int LW = PW + 1;
    localparam int WW = 1 + OW + LW;
    localparam int AW = ((LW > ORDER_LEVELS) ? LW : ORDER_LEVELS) + 1;
    localparam int JW = $clog2(ORDER_LEVELS + 1);
    localparam logic [LW-1:0] NIL = LW'(PAGE_COUNT);
    localparam logic [OW-1:0] TOP = OW'(ORDER_LEVELS - 1);
    localparam logic [AW-1:0] PC_A = AW'(PAGE_COUNT);

    // word: free flag, order, link
    logic [WW-1:0] r_mem [PAGE_COUNT];
    logic [WW-1:0] r_rd;
    logic [PW-1:0] mem_addr;
    logic          mem_we;
    logic          mem_re;
    logic [WW-1:0] mem_wd;

    logic [LW-1:0] r_heads [ORDER_LEVELS];
    logic [LW-1:0] n_heads [ORDER_LEVELS];
    logic [PW-1:0] r_idx, n_idx;
    logic          r_cmd, n_cmd;
    logic [OW-1:0] r_k, n_k;
    logic [JW-1:0] r_j, n_j;
    logic [LW-1:0] r_cur, n_cur;
    logic [PW-1:0] r_p, n_p;
    logic [PW-1:0] r_b, n_b;
    logic [PW-1:0] r_tgt, n_tgt;
    logic [OW-1:0] r_o, n_o;
    logic [LW-1:0] r_prev, n_prev;
    logic [WW-1:0] r_prevw, n_prevw;
    logic [LW-1:0] r_lnk, n_lnk;
    logic [LW-1:0] r_steps, n_steps;
    logic          r_phase, n_phase;
    logic [1:0]    r_res_status, n_res_status;
    logic [PW-1:0] r_res_page, n_res_page;
    logic          r_out_valid, n_out_valid;
    logic [1:0]    r_status, n_status;
    logic [PW-1:0] r_page, n_page;

    logic          rd_free;
    logic [OW-1:0] rd_order;
    logic [LW-1:0] rd_link;
    logic [JW-1:0] j_dec;
    logic [OW-1:0] j_lo;
    logic [OW-1:0] j_idx;
    logic [AW-1:0] upper;
    logic [AW-1:0] buddy;
    logic [AW-1:0] align_mask;
    logic [OW-1:0] o_inc;
    logic [PW-1:0] lo_page;

    assign rd_free    = r_rd[WW-1];
    assign rd_order   = r_rd[WW-2 -: OW];
    assign rd_link    = r_rd[LW-1:0];
    assign j_dec      = r_j - JW'(1);
    assign j_lo       = j_dec[OW-1:0];
    assign j_idx      = r_j[OW-1:0];
    assign upper      = AW'(r_cur) + (AW'(1) << j_lo);
    assign buddy      = AW'(r_p) ^ (AW'(1) << r_o);
    assign align_mask = (AW'(1) << rd_order) - AW'(1);
    assign o_inc      = r_o + OW'(1);
    assign lo_page    = (r_p < r_b) ? r_p : r_b;

    always_comb begin
        o_flags.clear_last  = (r_idx == PW'(PAGE_COUNT - 1));
        o_flags.is_free_cmd = r_cmd;
        o_flags.k_bad       = (32'(r_k) >= ORDER_LEVELS);
        o_flags.p_bad       = (32'(r_p) >= PAGE_COUNT);
        o_flags.head_ok     = (r_heads[j_idx] != NIL);
        o_flags.j_last      = (r_j == JW'(ORDER_LEVELS - 1));
        o_flags.j_gt_k      = (r_j > JW'(r_k));
        o_flags.rd_bad      = rd_free || (32'(rd_order) >= ORDER_LEVELS)
                              || ((AW'(r_p) & align_mask) != '0);
        o_flags.merge_stop  = (r_o == TOP) || (buddy >= PC_A);
        o_flags.no_merge    = !rd_free || (rd_order != r_o);
        o_flags.walk_end    = (r_cur >= NIL) || (r_steps >= NIL);
        o_flags.cur_hit     = (r_cur[PW-1:0] == r_tgt);
        o_flags.prev_nil    = (r_prev == NIL);
        o_flags.phase       = r_phase;
        o_flags.out_busy    = r_out_valid && !i_out_ready;
    end

    always_comb begin
        n_heads      = r_heads;
        n_idx        = r_idx;
        n_cmd        = r_cmd;
        n_k          = r_k;
        n_j          = r_j;
        n_cur        = r_cur;
        n_p          = r_p;
        n_b          = r_b;
        n_tgt        = r_tgt;
        n_o          = r_o;
        n_prev       = r_prev;
        n_prevw      = r_prevw;
        n_lnk        = r_lnk;
        n_steps      = r_steps;
        n_phase      = r_phase;
        n_res_status = r_res_status;
        n_res_page   = r_res_page;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_status     = r_status;
        n_page       = r_page;
        mem_addr     = r_cur[PW-1:0];
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_wd       = '0;
        unique case (i_op)
            OP_NONE: begin
            end
            OP_CLEAR: begin
                mem_addr = r_idx;
                mem_we   = 1'b1;
                mem_wd   = (r_idx == '0) ? {1'b1, TOP, NIL} : {1'b0, OW'(0), NIL};
                n_idx    = r_idx + PW'(1);
            end
            OP_LOAD: begin
                n_cmd = i_command;
                n_k   = i_size_order;
                n_j   = JW'(i_size_order);
                n_p   = i_page_index;
            end
            OP_J_INC: n_j = r_j + JW'(1);
            OP_A_TAKE: begin
                n_cur    = r_heads[j_idx];
                mem_addr = r_heads[j_idx][PW-1:0];
                mem_re   = 1'b1;
            end
            OP_A_POP: n_heads[j_idx] = rd_link;
            OP_A_SPLIT: begin
                // if upper fits: push lower one order down, go on with upper
                n_j = j_dec;
                if (upper < PC_A) begin
                    mem_we         = 1'b1;
                    mem_wd         = {1'b1, j_lo, r_heads[j_lo]};
                    n_heads[j_lo]  = r_cur;
                    n_cur          = upper[LW-1:0];
                end
            end
            OP_A_FINAL: begin
                mem_we       = 1'b1;
                mem_wd       = {1'b0, r_k, NIL};
                n_res_status = ST_OK;
                n_res_page   = r_cur[PW-1:0];
            end
            OP_F_RD: begin
                mem_addr = r_p;
                mem_re   = 1'b1;
            end
            OP_F_PUSH: begin
                mem_addr          = r_p;
                mem_we            = 1'b1;
                mem_wd            = {1'b1, rd_order, r_heads[rd_order]};
                n_heads[rd_order] = LW'(r_p);
                n_o               = rd_order;
            end
            OP_M_RD: begin
                n_b      = buddy[PW-1:0];
                mem_addr = buddy[PW-1:0];
                mem_re   = 1'b1;
            end
            OP_U_START_P: begin
                n_tgt   = r_p;
                n_cur   = r_heads[r_o];
                n_prev  = NIL;
                n_steps = '0;
                n_phase = 1'b0;
            end
            OP_U_START_B: begin
                n_tgt   = r_b;
                n_cur   = r_heads[r_o];
                n_prev  = NIL;
                n_steps = '0;
                n_phase = 1'b1;
            end
            OP_U_RD: mem_re = 1'b1;
            OP_U_ADV: begin
                n_prevw = r_rd;
                n_prev  = r_cur;
                n_cur   = rd_link;
                n_steps = r_steps + LW'(1);
            end
            OP_U_FIX1: begin
                mem_we = 1'b1;
                mem_wd = {1'b0, rd_order, NIL};
                n_lnk  = rd_link;
                if (r_prev == NIL) n_heads[r_o] = rd_link;
            end
            OP_U_FIX2: begin
                mem_addr = r_prev[PW-1:0];
                mem_we   = 1'b1;
                mem_wd   = {r_prevw[WW-1:LW], r_lnk};
            end
            OP_M_PUSH: begin
                mem_addr       = lo_page;
                mem_we         = 1'b1;
                mem_wd         = {1'b1, o_inc, r_heads[o_inc]};
                n_heads[o_inc] = LW'(lo_page);
                n_o            = o_inc;
                n_p            = lo_page;
            end
            OP_RES_OOM: begin
                n_res_status = ST_OOM;
                n_res_page   = '0;
            end
            OP_RES_BIG: begin
                n_res_status = ST_BIG;
                n_res_page   = '0;
            end
            OP_RES_DUP: begin
                n_res_status = ST_DUP;
                n_res_page   = '0;
            end
            OP_RES_OKF: begin
                n_res_status = ST_OK;
                n_res_page   = '0;
            end
            OP_EMIT: begin
                n_out_valid = 1'b1;
                n_status    = r_res_status;
                n_page      = r_res_page;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ORDER_LEVELS; i++) begin
                r_heads[i] <= (i == ORDER_LEVELS - 1) ? LW'(0) : NIL;
            end
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_heads     <= n_heads;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_k          <= n_k;
        r_j          <= n_j;
        r_cur        <= n_cur;
        r_p          <= n_p;
        r_b          <= n_b;
        r_tgt        <= n_tgt;
        r_o          <= n_o;
        r_prev       <= n_prev;
        r_prevw      <= n_prevw;
        r_lnk        <= n_lnk;
        r_steps      <= n_steps;
        r_phase      <= n_phase;
        r_res_status <= n_res_status;
        r_res_page   <= n_res_page;
        r_status     <= n_status;
        r_page       <= n_page;
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_block_page = r_page;

endmodule

@@ rtl/buddy_page_allocator_top.sv @@
// Top level of the buddy page allocator: sequencer plus page table datapath.
//
//  channel  | dir | signals                                  | accepted when
//  ---------+-----+------------------------------------------+---------------------
//  i_req    | in  | command, size_order, page_index          | valid && ready
//  o_rsp    | out | status, block_page                       | valid && ready
//
// After reset a clearing pass writes every page table entry with i_req.ready
// low. Requests are served one at a time from a single-port page table: an
// allocate scans the free lists upward from the requested order, takes a block
// and splits it; a free merges with its buddy while it can, and each merge
// walks one free list twice to unlink both blocks. The result waits in an output
// register; a stalled o_rsp holds the sequencer only at the end of the next item.
module buddy_page_allocator_top #(
    parameter int PAGE_COUNT   = 512,
    parameter int ORDER_LEVELS = 10
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bpa_req_if.sink   i_req,
    bpa_rsp_if.source o_rsp
);
    import bpa_pkg::*;

    localparam int PW = $clog2(PAGE_COUNT);
    localparam int OW = $clog2(ORDER_LEVELS);

    t_dp_op    op;
    t_dp_flags flags;

    // Sequencer: one datapath operation per cycle.
    bpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_flags    (flags),
        .o_in_ready (i_req.ready),
        .o_op       (op)
    );

    // Page table, list heads and the result register.
    bpa_datapath #(
        .PAGE_COUNT   (PAGE_COUNT),
        .ORDER_LEVELS (ORDER_LEVELS),
        .PW           (PW),
        .OW           (OW)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (op),
        .i_command    (i_req.command),
        .i_size_order (i_req.size_order),
        .i_page_index (i_req.page_index),
        .i_out_ready  (o_rsp.ready),
        .o_flags      (flags),
        .o_out_valid  (o_rsp.valid),
        .o_status     (o_rsp.status),
        .o_block_page (o_rsp.block_page)
    );

endmodule

@@ rtl/bpa_checker.sv @@
// Port-level checks of the buddy page allocator, bound to the top level.
module bpa_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_status,
    input logic       i_page_zero
);
    import bpa_pkg::*;

    // one request in flight: ready drops right after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request accepted while another is in flight");

    // failed results carry page zero (successful frees report ok and are not checked here)
    a_page_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status != ST_OK)) |-> i_page_zero)
        else $error("non-ok result with nonzero page");

    // a stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

endmodule

bind buddy_page_allocator_top bpa_checker u_bpa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_page_zero (o_rsp.block_page == '0)
);
